### rtl/gbsq_pkg.sv
// Shared types, constants and helpers of the GF(2) basis span query core.
package gbsq_pkg;

   localparam int WORD_W = 64;
   localparam int BIT_W  = 6;
   localparam int ANS_W  = 12;
   localparam int CFG_W  = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BIT_W-1:0]  bitpos_type;

   // Priority encoder: position of the lowest set bit, zero for a zero word.
   function automatic bitpos_type low_bit(input word_type w);
      bitpos_type pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

### rtl/gbsq_basis_ram.sv
// Basis row storage: one 64-bit word per address, registered read.
module gbsq_basis_ram #(
   parameter int AW = 10
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       addr,
   input  gbsq_pkg::word_type  wdata,
   output gbsq_pkg::word_type  rdata
);

   gbsq_pkg::word_type mem [2**AW];
   gbsq_pkg::word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/gbsq_pivot_tab.sv
// Pivot table: row number per pivot bit, with a valid flag per entry.
module gbsq_pivot_tab #(
   parameter int PW = 8,
   parameter int RW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [PW-1:0] addr,
   input  logic          we,
   input  logic [RW-1:0] wrow,
   output logic          rd_valid,
   output logic [RW-1:0] rd_row
);

   logic [RW-1:0]      mem [2**PW];
   logic [2**PW-1:0]   valid_ff;
   logic [2**PW-1:0]   valid_in;
   logic               rd_valid_ff;
   logic [RW-1:0]      rd_row_ff;

   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wrow;
      end
      rd_row_ff <= mem[addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_row   = rd_row_ff;

endmodule

### rtl/gf2_basis_span_query_core.sv
// Operation: n-1 word requests are collected, then on the last word a reduction of
//   up to VEC_WORDS*64 steps runs, each a word scan, a pivot read and n basis words XORed, n = active words.
// Throughput: one word request per cycle while collecting, then busy for the reduction;
//   an independent insert also writes all VEC_WORDS words of its basis row.
// The loop through the pivot table and the single-port basis RAM limits the reduction.
// Reset: synchronous, clears control state, pivot valid flags, counters; no memory sweep.
module gf2_basis_span_query_core #(
   parameter int VEC_WORDS = 4,
   parameter int MAX_ROWS  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] word
   input  logic [0:0]  req_tuser,   // [0] mode (1 query)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] answer, [15:12] zero
   output logic [2:0]  rsp_tuser,   // [0] independent, [1] was_query, [2] row_overflow
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW   = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
   localparam int NW   = $clog2(VEC_WORDS + 1);
   localparam int PW   = IW + gbsq_pkg::BIT_W;
   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int AW   = PW + IW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PVRD = 3'd2;
   localparam logic [2:0] ST_PCHK = 3'd3;
   localparam logic [2:0] ST_BRD  = 3'd4;
   localparam logic [2:0] ST_BXOR = 3'd5;
   localparam logic [2:0] ST_WRB  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   // configuration
   logic [gbsq_pkg::CFG_W-1:0] act_words_ff, act_words_in;
   logic [NW-1:0]              eff_n;

   // sequencer state
   logic [2:0]                 state_ff, state_in;
   logic [IW-1:0]              wcnt_ff, wcnt_in;
   logic [NW-1:0]              w_ff, w_in;
   logic [PW-1:0]              piv_ff, piv_in;
   logic                       query_ff, query_in;
   logic [RW-1:0]              rows_ff, rows_in;
   logic signed [RW:0]         first_dep_ff, first_dep_in;
   logic signed [RW:0]         used_ff, used_in;
   gbsq_pkg::word_type         wv_ff [VEC_WORDS];
   gbsq_pkg::word_type         wv_in [VEC_WORDS];

   // pending result
   logic signed [RW:0]         res_ans_ff, res_ans_in;
   logic                       res_ind_ff, res_ind_in;
   logic                       res_ovf_ff, res_ovf_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [gbsq_pkg::ANS_W-1:0] rsp_ans_ff, rsp_ans_in;
   logic [2:0]                 rsp_flags_ff, rsp_flags_in;

   // memory ports
   logic                       bas_we;
   logic [AW-1:0]              bas_addr;
   gbsq_pkg::word_type         bas_wdata, bas_rdata;
   logic                       piv_we;
   logic                       piv_valid;
   logic [RW-1:0]              piv_row;

   logic                       req_fire, last_word, csr_write;
   logic signed [31:0]         ans_wide;
   logic [IW-1:0]              widx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {29'd0, act_words_ff} : 32'd0;

   // clamp active words: zero acts as one, above the size acts as full size
   always_comb begin
      if (act_words_ff == '0) begin
         eff_n = NW'(1);
      end else if (32'(act_words_ff) > VEC_WORDS) begin
         eff_n = NW'(VEC_WORDS);
      end else begin
         eff_n = NW'(act_words_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign last_word  = (32'(wcnt_ff) + 1 >= 32'(eff_n));
   assign widx       = w_ff[IW-1:0];

   always_comb begin
      act_words_in = act_words_ff;
      if (csr_write) begin
         act_words_in = csr_pwdata[gbsq_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      wcnt_in      = wcnt_ff;
      w_in         = w_ff;
      piv_in       = piv_ff;
      query_in     = query_ff;
      rows_in      = rows_ff;
      first_dep_in = first_dep_ff;
      used_in      = used_ff;
      wv_in        = wv_ff;
      res_ans_in   = res_ans_ff;
      res_ind_in   = res_ind_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ans_in   = rsp_ans_ff;
      rsp_flags_in = rsp_flags_ff;
      bas_we       = 1'b0;
      bas_addr     = {piv_ff, widx};
      bas_wdata    = (w_ff < eff_n) ? wv_ff[widx] : '0;
      piv_we       = 1'b0;
      ans_wide     = 32'(res_ans_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wv_in[wcnt_ff] = req_tdata;
               if (!last_word) begin
                  wcnt_in = wcnt_ff + 1'b1;
               end else begin
                  // vector complete: start reduction or reject overflow
                  wcnt_in    = '0;
                  w_in       = '0;
                  query_in   = req_tuser[0];
                  used_in    = '1;
                  res_ind_in = 1'b0;
                  res_ovf_in = 1'b0;
                  if (!req_tuser[0] && rows_ff >= RW'(MAX_ROWS)) begin
                     res_ans_in = '1;
                     res_ovf_in = 1'b1;
                     state_in   = ST_FIN;
                  end else begin
                     if (!req_tuser[0]) begin
                        rows_in = rows_ff + 1'b1;
                     end
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (w_ff == eff_n) begin
               // vector reduced to zero
               if (query_ff) begin
                  res_ans_in = (used_ff < 0) ? first_dep_ff : used_ff;
               end else begin
                  if (first_dep_ff < 0) begin
                     first_dep_in = $signed({1'b0, rows_ff});
                  end
                  res_ans_in = $signed({1'b0, rows_ff});
               end
               state_in = ST_FIN;
            end else if (wv_ff[widx] != '0) begin
               piv_in   = {widx, gbsq_pkg::low_bit(wv_ff[widx])};
               state_in = ST_PVRD;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_PVRD: begin
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            w_in = '0;
            if (!piv_valid) begin
               // nonzero remainder with a free pivot
               if (query_ff) begin
                  res_ans_in = '1;
                  state_in   = ST_FIN;
               end else begin
                  piv_we     = 1'b1;
                  res_ans_in = $signed({1'b0, rows_ff});
                  res_ind_in = 1'b1;
                  state_in   = ST_WRB;
               end
            end else begin
               if ($signed({1'b0, piv_row}) > used_ff) begin
                  used_in = $signed({1'b0, piv_row});
               end
               state_in = ST_BRD;
            end
         end
         ST_BRD: begin
            state_in = ST_BXOR;
         end
         ST_BXOR: begin
            wv_in[widx] = wv_ff[widx] ^ bas_rdata;
            if (w_ff + 1'b1 == eff_n) begin
               w_in     = '0;
               state_in = ST_SCAN;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_BRD;
            end
         end
         ST_WRB: begin
            bas_we = 1'b1;
            if (w_ff == NW'(VEC_WORDS - 1)) begin
               state_in = ST_FIN;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_FIN: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = ans_wide[gbsq_pkg::ANS_W-1:0];
               rsp_flags_in = {res_ovf_ff, query_ff, res_ind_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_words_ff <= gbsq_pkg::CFG_W'(4);
         state_ff     <= ST_IDLE;
         wcnt_ff      <= '0;
         w_ff         <= '0;
         rows_ff      <= '0;
         first_dep_ff <= '1;
         used_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_words_ff <= act_words_in;
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         w_ff         <= w_in;
         rows_ff      <= rows_in;
         first_dep_ff <= first_dep_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      piv_ff       <= piv_in;
      query_ff     <= query_in;
      wv_ff        <= wv_in;
      res_ans_ff   <= res_ans_in;
      res_ind_ff   <= res_ind_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_ans_ff   <= rsp_ans_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - gbsq_pkg::ANS_W){1'b0}}, rsp_ans_ff};
   assign rsp_tuser  = rsp_flags_ff;

   gbsq_basis_ram #(
      .AW (AW)
   ) u_basis (
      .clock (clock),
      .we    (bas_we),
      .addr  (bas_addr),
      .wdata (bas_wdata),
      .rdata (bas_rdata)
   );

   gbsq_pivot_tab #(
      .PW (PW),
      .RW (RW)
   ) u_pivot (
      .clock    (clock),
      .reset    (reset),
      .addr     (piv_ff),
      .we       (piv_we),
      .wrow     (rows_ff),
      .rd_valid (piv_valid),
      .rd_row   (piv_row)
   );

`ifndef SYNTHESIS
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= RW'(MAX_ROWS))
      else $error("row count above limit");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= $signed({1'b0, rows_ff}))
      else $error("used row beyond row count");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FIN))
      else $error("result left while response slot busy");

   a_xor_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BXOR) |-> (w_ff < eff_n))
      else $error("xor word index beyond vector");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the GF(2) basis span query core.
module tb_top;

   localparam int NWORDS      = 4;
   localparam int ROW_LIMIT   = 1024;
   localparam int NPIVOTS     = NWORDS * 64;
   localparam int SETTLE      = 64;
   localparam int STUCK_LIMIT = 40000;
   localparam int HOLD_CYCLES = 1500;
   localparam logic [2:0] AW_ADDR = 3'd0;

   typedef enum logic {MODE_INSERT = 1'b0, MODE_QUERY = 1'b1} mode_type;

   typedef struct {
      mode_type           mode;
      gbsq_pkg::word_type word;
   } request_type;

   typedef struct {
      logic [gbsq_pkg::ANS_W-1:0] answer;
      logic                       independent;
      logic                       was_query;
      logic                       row_overflow;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] word
   logic [0:0]  req_tuser = '0;   // [0] mode (1 query)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [11:0] answer, [15:12] zero
   logic [2:0]  rsp_tuser;        // [0] independent, [1] was_query, [2] row_overflow
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gf2_basis_span_query_core #(.VEC_WORDS(NWORDS), .MAX_ROWS(ROW_LIMIT)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mirror of the block's state, updated as requests are accepted.
   gbsq_pkg::word_type basis_rows [NPIVOTS][NWORDS];
   int                 pivot_owner [NPIVOTS];   // 0 marks an empty pivot
   gbsq_pkg::word_type gathered [NWORDS];
   int                 words_held;
   int                 rows_taken;
   int                 first_dep_row;
   logic [2:0]         aw_reg;

   request_type        pending_requests [$];
   span_result_type    expected_results [$];
   gbsq_pkg::word_type inserted_vecs [$][NWORDS];

   int  mismatches = 0;
   int  drv_gap = 0;
   int  rcv_stall = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  no_idle = 1'b0;
   int  stuck_cycles = 0;

   function automatic int words_in_use();
      if (aw_reg == 0) return 1;
      if (aw_reg > NWORDS) return NWORDS;
      return int'(aw_reg);
   endfunction

   function automatic int lowest_set(input gbsq_pkg::word_type v [NWORDS], input int n);
      for (int w = 0; w < n; w++) begin
         for (int b = 0; b < 64; b++) begin
            if (v[w][b]) return w * 64 + b;
         end
      end
      return -1;
   endfunction

   // Word count used by each random phase.
   function automatic logic [2:0] aw_for_phase(input int ph);
      case (ph)
         0: return 3'd1;
         1: return 3'd2;
         2: return 3'd4;
         3: return 3'd3;
         4: return 3'd1;
         default: return 3'd5;
      endcase
   endfunction

   // Advance the mirror by one accepted request; queue the result it causes.
   function automatic void absorb_request(input request_type rq);
      int n, slot, piv, maxrow, ans;
      gbsq_pkg::word_type v [NWORDS];
      span_result_type res;
      n = words_in_use();
      slot = (words_held >= NWORDS) ? NWORDS - 1 : words_held;
      gathered[slot] = rq.word;
      if (slot + 1 < n) begin
         words_held = slot + 1;
         return;
      end
      words_held = 0;
      for (int w = 0; w < NWORDS; w++) v[w] = (w < n) ? gathered[w] : '0;
      res = '{answer: '0, independent: 1'b0, was_query: rq.mode == MODE_QUERY,
              row_overflow: 1'b0};
      if (rq.mode == MODE_INSERT && rows_taken >= ROW_LIMIT) begin
         res.answer = '1;
         res.row_overflow = 1'b1;
         expected_results.insert(expected_results.size(), res);
         return;
      end
      if (rq.mode == MODE_QUERY && lowest_set(v, n) < 0) begin
         res.answer = gbsq_pkg::ANS_W'(first_dep_row);
         expected_results.insert(expected_results.size(), res);
         return;
      end
      maxrow = -1;
      piv = lowest_set(v, n);
      while (piv >= 0 && pivot_owner[piv] != 0) begin
         if (pivot_owner[piv] > maxrow) maxrow = pivot_owner[piv];
         for (int w = 0; w < n; w++) v[w] ^= basis_rows[piv][w];
         piv = lowest_set(v, n);
      end
      if (rq.mode == MODE_QUERY) begin
         ans = (piv < 0) ? maxrow : -1;
      end else begin
         rows_taken++;
         if (piv >= 0) begin
            for (int w = 0; w < NWORDS; w++) basis_rows[piv][w] = v[w];
            pivot_owner[piv] = rows_taken;
            res.independent = 1'b1;
         end else if (first_dep_row < 0) begin
            first_dep_row = rows_taken;
         end
         ans = rows_taken;
      end
      res.answer = gbsq_pkg::ANS_W'(ans);
      expected_results.insert(expected_results.size(), res);
   endfunction

   // Driver: present queued requests, with a drawn gap after each one.
   always @(posedge clock) begin
      logic nv;
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            rq.mode = mode_type'(req_tuser[0]);
            rq.word = req_tdata;
            absorb_request(rq);
            nv = 1'b0;
            drv_gap = no_idle ? 0 : $urandom_range(6);
         end
         if (!nv) begin
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_tdata <= rq.word;
               req_tuser <= rq.mode;
               nv = 1'b1;
            end
         end
         req_tvalid <= nv;
      end
   end

   // Monitor: compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      logic nr;
      span_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rcv_stall = no_idle ? 0 : $urandom_range(6);
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_tdata !== {4'b0, exp_res.answer} ||
                   rsp_tuser !== {exp_res.row_overflow, exp_res.was_query,
                                  exp_res.independent}) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected answer=%h ovf=%b query=%b indep=%b,",
                              exp_res.answer, exp_res.row_overflow, exp_res.was_query,
                              exp_res.independent, " got tdata=%h tuser=%b",
                              rsp_tdata, rsp_tuser);
               end
            end
         end
         // A hold request starts one long stall so the block backs up into its input.
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
         end else if (rcv_stall > 0) begin
            rcv_stall--;
            nr = 1'b0;
         end else begin
            nr = 1'b1;
         end
         rsp_tready <= nr;
      end
   end

   // Watchdog: count cycles with no handshake on either channel and no receiver hold.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_left > 0)
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Write the word count register, then read it back.
   task automatic set_active_words(input logic [2:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= AW_ADDR;
      csr_pwdata <= {29'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      aw_reg = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {29'b0, aw_reg}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register readback: expected %0d got %h", aw_reg, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold until every request is taken, the block is idle and every result has arrived.
   task automatic drain();
      @(negedge clock);
      while (pending_requests.size() > 0 || req_tvalid || expected_results.size() > 0 ||
             !req_tready || rsp_tvalid)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic gbsq_pkg::word_type random_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return gbsq_pkg::word_type'(1) << $urandom_range(63);
         3: return (gbsq_pkg::word_type'(1) << $urandom_range(63)) |
                   (gbsq_pkg::word_type'(1) << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void push_vector(input mode_type mode,
                                       input gbsq_pkg::word_type v [NWORDS]);
      int n;
      request_type rq;
      n = words_in_use();
      for (int w = 0; w < n; w++) begin
         rq.word = v[w];
         // Only the mode of the last word counts; scramble the others.
         rq.mode = (w == n - 1) ? mode : mode_type'($urandom_range(1));
         pending_requests.insert(pending_requests.size(), rq);
      end
   endfunction

   function automatic void one_vector(input mode_type mode, input gbsq_pkg::word_type w0,
                                      input gbsq_pkg::word_type w1);
      gbsq_pkg::word_type v [NWORDS];
      v[0] = w0;
      v[1] = w1;
      v[2] = '1;
      v[3] = gbsq_pkg::word_type'(1) << 63;
      push_vector(mode, v);
   endfunction

   // Mostly well-formed traffic: fresh rows, sums of earlier rows, span queries.
   function automatic void random_phase(input int count);
      gbsq_pkg::word_type v [NWORDS];
      mode_type mode;
      inserted_vecs.delete();
      for (int i = 0; i < count; i++) begin
         mode = mode_type'($urandom_range(1));
         if (inserted_vecs.size() > 0 && $urandom_range(99) < 55) begin
            v = '{default: '0};
            for (int k = 0; k < inserted_vecs.size(); k++) begin
               if ($urandom_range(2) == 0) begin
                  for (int w = 0; w < NWORDS; w++) v[w] ^= inserted_vecs[k][w];
               end
            end
         end else begin
            for (int w = 0; w < NWORDS; w++) v[w] = random_word();
         end
         if (mode == MODE_INSERT) inserted_vecs.insert(inserted_vecs.size(), v);
         push_vector(mode, v);
      end
   endfunction

   initial begin
      request_type rq;
      for (int p = 0; p < NPIVOTS; p++) pivot_owner[p] = 0;
      words_held = 0;
      rows_taken = 0;
      first_dep_row = -1;
      aw_reg = 3'd4;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-word vectors and the edges of the word values.
      set_active_words(3'd1);
      one_vector(MODE_QUERY, '0, '0);
      one_vector(MODE_QUERY, 64'h1, '0);
      one_vector(MODE_INSERT, '0, '0);
      one_vector(MODE_INSERT, '1, '0);
      one_vector(MODE_INSERT, 64'h8000_0000_0000_0000, '0);
      one_vector(MODE_INSERT, 64'h7fff_ffff_ffff_ffff, '0);
      one_vector(MODE_QUERY, '0, '0);
      one_vector(MODE_QUERY, '1, '0);
      one_vector(MODE_QUERY, 64'h8000_0000_0000_0001, '0);
      one_vector(MODE_QUERY, 64'h2, '0);
      drain();
      // Zero words behaves like one word.
      set_active_words(3'd0);
      one_vector(MODE_INSERT, 64'h10, '0);
      one_vector(MODE_QUERY, 64'h10, '0);
      drain();
      // Above the word count, behaves like the full width.
      set_active_words(3'd7);
      one_vector(MODE_INSERT, '0, 64'h1);
      one_vector(MODE_QUERY, 64'h10, '0);
      drain();
      // Shrink the word count while a vector is half gathered.
      set_active_words(3'd4);
      rq = '{mode: MODE_INSERT, word: 64'h100};
      pending_requests.insert(pending_requests.size(), rq);
      pending_requests.insert(pending_requests.size(), rq);
      drain();
      set_active_words(3'd2);
      rq = '{mode: MODE_QUERY, word: 64'h3};
      pending_requests.insert(pending_requests.size(), rq);
      drain();

      // Random phases across word counts; one long receiver hold.
      for (int ph = 0; ph < 6; ph++) begin
         set_active_words(aw_for_phase(ph));
         no_idle = (ph % 3 == 1);
         random_phase(aw_for_phase(ph) >= 3'd3 ? 12 : 30);
         if (ph == 1) hold_request = 1'b1;
         drain();
      end

      // Fill the row counter to its limit with cheap zero inserts, then insert past it.
      set_active_words(3'd1);
      no_idle = 1'b1;
      for (int i = rows_taken; i < ROW_LIMIT + 3; i++) one_vector(MODE_INSERT, '0, '0);
      one_vector(MODE_QUERY, '0, '0);
      one_vector(MODE_INSERT, 64'h4000, '0);
      one_vector(MODE_QUERY, 64'h1, '0);
      drain();

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
